// ===== hdl/tks_pkg.sv =====
// Shared types and constants for the top-k score table.
package tks_pkg;

    localparam int CAPACITY = 10;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of one record
    localparam int SCORE_W = 31;
    localparam int WAVE_W  = 16;
    localparam int KILLS_W = 16;
    localparam int TAG_W   = 8;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 4;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 4;

    // Command codes carried in tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [TAG_W-1:0]   tag;
        logic [KILLS_W-1:0] kills;
        logic [WAVE_W-1:0]  wave;
        logic [SCORE_W-1:0] score;
    } rec_t;

    // What one cell hands to the next one down the row
    typedef struct packed {
        logic valid;
        logic hit;
        rec_t rec;
    } link_t;

endpackage

// ===== hdl/tks_cell.sv =====
// One rank of the sorted table: holds a record and shifts or loads on insert.
module tks_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ins_en,
    input  tks_pkg::rec_t new_rec,
    input  tks_pkg::link_t prev,
    output tks_pkg::link_t own
);
    import tks_pkg::*;

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;
    rec_t rec_next;
    logic hit;
    logic take_new;
    logic take_prev;

    // New record belongs here or above: slot empty or new score strictly higher
    assign hit       = !valid_reg || (new_rec.score > rec_reg.score);
    assign take_new  = ins_en && hit && !prev.hit;
    assign take_prev = ins_en && hit && prev.hit;

    // Load the new record, shift the neighbour's down, or hold
    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (take_new) begin
            valid_next = 1'b1;
            rec_next   = new_rec;
        end else if (take_prev) begin
            valid_next = prev.valid;
            rec_next   = prev.rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign own.valid = valid_reg;
    assign own.hit   = hit;
    assign own.rec   = rec_reg;

endmodule

// ===== hdl/top_k_score_table_unit.sv =====
// Top-k score table: a row of rank cells kept in descending score order.
// The accepted beat is captured with exec_reg set; the result beat is then registered
// into out_data_reg and out_valid_reg.
// Only one beat is in flight: the next is taken once the result beat has left.
// An insert loads or shifts the affected ranks of the cell row together; a read selects one rank.
// Reset (aresetn low, synchronous) empties the table and drops any beat in flight.
module top_k_score_table_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // score[30:0], wave[46:31], kills[62:47], player_tag[70:63],
    // timestamp[102:71], read_index[106:103], zero[111:107]
    input  logic [111:0]  s_axis_tdata,
    // command[0]
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // accepted[0], position[4:1], entry_count[8:5], entry_valid[9],
    // entry_score[40:10], entry_wave[56:41], entry_kills[72:57], entry_tag[80:73],
    // entry_timestamp[112:81], zero[119:113]
    output logic [119:0]  m_axis_tdata
);
    import tks_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 exec_reg;
    logic                 exec_next;
    logic                 cmd_reg;
    rec_t                 in_rec_reg;
    logic [IDX_W-1:0]     ridx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [119:0]         out_data_reg;
    logic [119:0]         out_data_next;

    logic                 s_beat;
    logic                 m_beat;
    logic                 ins_en;
    link_t                links [CAPACITY+1];
    logic                 any_hit;
    logic [POS_W-1:0]     ins_pos;
    logic                 rd_valid;
    rec_t                 rd_rec;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            cmd_reg    <= s_axis_tuser[0];
            in_rec_reg <= s_axis_tdata[102:0];
            ridx_reg   <= s_axis_tdata[106:103];
        end
    end

    assign ins_en = exec_reg && (cmd_reg == CMD_INSERT);

    // Row of rank cells, rank 0 at the head
    assign links[0] = '0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        tks_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ins_en  (ins_en),
            .new_rec (in_rec_reg),
            .prev    (links[g]),
            .own     (links[g+1])
        );
    end

    // Find the insert rank and select the read rank
    always_comb begin
        any_hit  = 1'b0;
        ins_pos  = '0;
        rd_valid = (CNT_W'(ridx_reg) < cnt_reg) && (int'(ridx_reg) < CAPACITY);
        rd_rec   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (links[i+1].hit) begin
                any_hit = 1'b1;
                ins_pos = POS_W'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (rd_valid && (int'(ridx_reg) == i)) begin
                rd_rec = links[i+1].rec;
            end
        end
    end

    // Advance the control: busy from accept until the result beat leaves
    always_comb begin
        busy_next      = busy_reg;
        exec_next      = 1'b0;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_beat) begin
            busy_next = 1'b1;
            exec_next = 1'b1;
        end
        if (m_beat) begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (exec_reg) begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (cmd_reg == CMD_INSERT) begin
                if (any_hit) begin
                    if (cnt_reg < CNT_W'(CAPACITY)) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    out_data_next[0]   = 1'b1;
                    out_data_next[4:1] = ins_pos;
                end
                out_data_next[8:5] = COUNT_W'(cnt_next);
            end else begin
                out_data_next[8:5]    = COUNT_W'(cnt_reg);
                out_data_next[9]      = rd_valid;
                out_data_next[112:10] = rd_rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            exec_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            exec_reg      <= exec_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    // Checks on the control and table state
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> busy_reg)
        else $error("result beat without an item in flight");

    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ins_en && !any_hit) |=> $stable(cnt_reg))
        else $error("rejected insert changed the entry count");

    a_pos_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[0]) |->
            (CNT_W'(out_data_reg[4:1]) < cnt_reg))
        else $error("insert rank outside the table");

    a_one_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_reg |-> !out_valid_reg)
        else $error("item executed while a result is pending");

endmodule
